// ===== sv/mlp_pkg.sv =====
// ============================================================================
// mlp_pkg
// Shared types, sizes and constant tables for the 4-5-1 perceptron core.
// ============================================================================
package mlp_pkg;

    // Network shape and weight store size.
    localparam int HIDDEN_UNITS = 5;
    localparam int WEIGHT_COUNT = HIDDEN_UNITS * 6 + 1;
    localparam int WIDX_W       = $clog2(WEIGHT_COUNT);
    localparam int GENE_COUNT   = 31;

    // Accumulator width: covers the hidden sums and the output sum over all units.
    localparam int ACC_W = 34 + $clog2(HIDDEN_UNITS + 1);

    // Piecewise-linear tanh knots, tanh(k/2) in Q1.14.
    localparam int TANH_KNOTS = 17;
    localparam logic [15:0] TANH_KNOT [TANH_KNOTS] = '{
        16'd0,     16'd7571,  16'd12478, 16'd14830, 16'd15795, 16'd16165,
        16'd16303, 16'd16354, 16'd16373, 16'd16380, 16'd16383, 16'd16383,
        16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384
    };

    // Reset contents of the weight store in Q1.14.
    localparam logic signed [15:0] GENE_RESET [GENE_COUNT] = '{
        -16'sd9766,  -16'sd15128, -16'sd13448, -16'sd6041,  -16'sd9869,
        -16'sd649,   -16'sd7499,   16'sd4847,   16'sd10771, -16'sd4618,
        -16'sd1960,   16'sd6992,  -16'sd8597,   16'sd8915,   16'sd10256,
         16'sd264,   -16'sd3374,   16'sd11098,  16'sd14793, -16'sd7718,
        -16'sd11496,  16'sd15476, -16'sd12745,  16'sd1965,  -16'sd13100,
        -16'sd10535,  16'sd1393,  -16'sd14773, -16'sd15252, -16'sd3280,
        -16'sd9358
    };

    // Opcodes of an input item.
    localparam logic OP_INFER = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Input item.
    typedef struct packed {
        logic               opcode;
        logic signed [15:0] in_height;
        logic signed [15:0] in_distance;
        logic signed [15:0] in_velocity;
        logic signed [15:0] in_offset;
        logic [4:0]         weight_index;
        logic signed [15:0] weight_value;
    } mlp_in_t;

    // Result item.
    typedef struct packed {
        logic [15:0] probability;
        logic        flap;
    } mlp_out_t;

    // Control word for the shared multiply-accumulate unit.
    typedef struct packed {
        logic                    load;
        logic signed [ACC_W-1:0] load_value;
        logic                    mac_en;
        logic signed [16:0]      op_a;
        logic signed [16:0]      op_b;
    } mac_op_t;

    // Reset value of one weight slot; slots past the gene list start at zero.
    function automatic logic signed [15:0] gene_value(input int slot);
        logic signed [15:0] v;
        v = '0;
        if (slot < GENE_COUNT)
        begin
            v = GENE_RESET[slot];
        end
        return v;
    endfunction

endpackage

// ===== sv/mlp_weight_store.sv =====
// ============================================================================
// mlp_weight_store
// Register file of Q1.14 weights and biases, loaded with the gene values at
// reset, with one write port and one read port.
// ============================================================================
module mlp_weight_store (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [mlp_pkg::WIDX_W-1:0]       wr_addr,
    input  logic signed [15:0]               wr_data,
    input  logic [mlp_pkg::WIDX_W-1:0]       rd_addr,
    output logic signed [15:0]               rd_data
);
    import mlp_pkg::*;

    logic signed [15:0] slot_reg [WEIGHT_COUNT];

    // Each slot resets to its gene value and takes a write at its address.
    for (genvar i = 0; i < WEIGHT_COUNT; i++)
    begin : g_slot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                slot_reg[i] <= gene_value(i);
            end
            else if (wr_en && (int'(wr_addr) == i))
            begin
                slot_reg[i] <= wr_data;
            end
        end
    end

    // The sequencer only drives addresses inside the store.
    assign rd_data = slot_reg[rd_addr];

endmodule

// ===== sv/mlp_mac.sv =====
// ============================================================================
// mlp_mac
// Shared multiply-accumulate unit: a 17x17 signed multiplier feeding a wide
// accumulator that can also be loaded with a preset value.
// ============================================================================
module mlp_mac (
    input  logic                              clk,
    input  mlp_pkg::mac_op_t                  op,
    output logic signed [mlp_pkg::ACC_W-1:0]  acc
);
    import mlp_pkg::*;

    logic signed [33:0]      product;
    logic signed [ACC_W-1:0] acc_reg;

    assign product = op.op_a * op.op_b;

    // Load takes priority over accumulate.
    always_ff @(posedge clk)
    begin
        if (op.load)
        begin
            acc_reg <= op.load_value;
        end
        else if (op.mac_en)
        begin
            acc_reg <= acc_reg + {{(ACC_W - 34){product[33]}}, product};
        end
    end

    assign acc = acc_reg;

endmodule

// ===== sv/mlp_4_5_1_inference_core.sv =====
// ============================================================================
// mlp_4_5_1_inference_core
// Fixed-point 4-5-1 perceptron with tanh hidden units and a sigmoid output.
// ============================================================================
// Usage:
// An item is taken on a rising edge with start high and busy low. An item
// with opcode OP_WRITE stores weight_value in slot weight_index (slots past
// the store are ignored) in that same edge and keeps busy low; it gives no
// result. An item with opcode OP_INFER raises busy while the sequencer runs
// every product, bias and tanh interpolation through one multiply-accumulate
// unit: for each hidden unit a bias, four products, a round and three tanh
// steps, then for the output a bias, HIDDEN_UNITS products, a round and the
// three tanh steps. The result item appears on result with done high for
// exactly one cycle, the first cycle in which busy is low again, and a new
// item may be started in that same cycle; no item is taken while busy is
// high. The receiver cannot hold a result off, so none is ever stalled.
// Reset clears the sequencer and reloads the weight store with the gene
// values; it takes effect at once and needs no clearing pass.
// ============================================================================
module mlp_4_5_1_inference_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mlp_pkg::mlp_in_t  cmd,
    output mlp_pkg::mlp_out_t result,
    output logic              done
);
    import mlp_pkg::*;

    localparam int U_W = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HBIAS = 4'd1;
    localparam logic [3:0] S_HMAC  = 4'd2;
    localparam logic [3:0] S_ROUND = 4'd3;
    localparam logic [3:0] S_TSET  = 4'd4;
    localparam logic [3:0] S_TMAC  = 4'd5;
    localparam logic [3:0] S_TEND  = 4'd6;
    localparam logic [3:0] S_OBIAS = 4'd7;
    localparam logic [3:0] S_OMAC  = 4'd8;

    logic [3:0]          state_reg;
    logic [1:0]          k_reg;
    logic [U_W-1:0]      u_reg;
    logic [WIDX_W-1:0]   base_reg;
    logic                out_phase_reg;
    logic                done_reg;

    logic signed [15:0]  x_reg   [4];
    logic signed [15:0]  hid_reg [HIDDEN_UNITS];
    logic signed [15:0]  tx_reg;
    mlp_out_t            result_reg;

    logic                accept;
    logic                wr_en;
    logic [WIDX_W-1:0]   rd_addr;
    logic signed [15:0]  w;
    mac_op_t             mac_op;
    logic signed [ACC_W-1:0] acc;

    // Saturate a wide signed value to the Q3.12 range.
    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        r = v[15:0];
        if (v > $signed(ACC_W'(32767)))
        begin
            r = 16'sh7fff;
        end
        else if (v < -$signed(ACC_W'(32768)))
        begin
            r = 16'sh8000;
        end
        return r;
    endfunction

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign wr_en  = accept && (cmd.opcode == OP_WRITE)
                    && (int'(cmd.weight_index) < WEIGHT_COUNT);

    // Weight address for the current step.
    always_comb
    begin
        case (state_reg)
            S_HBIAS: rd_addr = base_reg + WIDX_W'(4);
            S_HMAC:  rd_addr = base_reg + WIDX_W'(k_reg);
            S_OBIAS: rd_addr = WIDX_W'(6 * HIDDEN_UNITS);
            S_OMAC:  rd_addr = WIDX_W'(5 * HIDDEN_UNITS) + WIDX_W'(u_reg);
            default: rd_addr = '0;
        endcase
    end

    mlp_weight_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (WIDX_W'(cmd.weight_index)),
        .wr_data (cmd.weight_value),
        .rd_addr (rd_addr),
        .rd_data (w)
    );

    // Tanh segment lookup on the saturated argument.
    logic        t_neg;
    logic [15:0] t_mag;
    logic [4:0]  t_idx;
    logic [10:0] t_frac;
    logic [15:0] t_knot;
    logic [15:0] t_diff;

    always_comb
    begin
        t_neg  = tx_reg[15];
        t_mag  = t_neg ? (16'd0 - tx_reg) : tx_reg;
        t_idx  = t_mag[15:11];
        t_frac = t_mag[10:0];
        if (t_idx >= 5'(TANH_KNOTS - 1))
        begin
            t_knot = TANH_KNOT[TANH_KNOTS - 1];
            t_diff = '0;
        end
        else
        begin
            t_knot = TANH_KNOT[t_idx];
            t_diff = TANH_KNOT[t_idx + 5'd1] - TANH_KNOT[t_idx];
        end
    end

    // Operations for the shared multiply-accumulate unit.
    always_comb
    begin
        mac_op = '0;
        case (state_reg)
            S_HBIAS:
            begin
                mac_op.load       = 1'b1;
                mac_op.load_value = {{(ACC_W - 28){w[15]}}, w, 12'd0}
                                    + ACC_W'(8192);
            end
            S_HMAC:
            begin
                mac_op.mac_en = 1'b1;
                mac_op.op_a   = {x_reg[k_reg][15], x_reg[k_reg]};
                mac_op.op_b   = {w[15], w};
            end
            S_TSET:
            begin
                mac_op.load       = 1'b1;
                mac_op.load_value = $signed({{(ACC_W - 27){1'b0}}, t_knot, 11'd0})
                                    + ACC_W'(1024);
            end
            S_TMAC:
            begin
                mac_op.mac_en = 1'b1;
                mac_op.op_a   = $signed({1'b0, t_diff});
                mac_op.op_b   = $signed({6'd0, t_frac});
            end
            S_OBIAS:
            begin
                mac_op.load       = 1'b1;
                mac_op.load_value = {{(ACC_W - 30){w[15]}}, w, 14'd0}
                                    + ACC_W'(65536);
            end
            S_OMAC:
            begin
                mac_op.mac_en = 1'b1;
                mac_op.op_a   = {hid_reg[u_reg][15], hid_reg[u_reg]};
                mac_op.op_b   = {w[15], w};
            end
            default:
            begin
                mac_op = '0;
            end
        endcase
    end

    mlp_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .acc (acc)
    );

    // Rounded and saturated sum, the signed tanh value and the output probability.
    logic signed [15:0] round_sat;
    logic signed [15:0] t_mag_y;
    logic signed [15:0] t_y;
    logic [17:0]        prob_wide;
    logic [15:0]        prob_sat;

    always_comb
    begin
        round_sat = out_phase_reg ? sat16(acc >>> 17) : sat16(acc >>> 14);
        t_mag_y   = $signed({1'b0, acc[25:11]});
        t_y       = t_neg ? -t_mag_y : t_mag_y;
        prob_wide = 18'($signed({{2{t_y[15]}}, t_y}) + 18'sd16384) << 1;
        prob_sat  = (prob_wide > 18'd65535) ? 16'hffff : prob_wide[15:0];
    end

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            u_reg         <= '0;
            base_reg      <= '0;
            out_phase_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (cmd.opcode == OP_INFER))
                    begin
                        k_reg         <= '0;
                        u_reg         <= '0;
                        base_reg      <= '0;
                        out_phase_reg <= 1'b0;
                        state_reg     <= S_HBIAS;
                    end
                end
                S_HBIAS:
                begin
                    state_reg <= S_HMAC;
                end
                S_HMAC:
                begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    state_reg <= S_TSET;
                end
                S_TSET:
                begin
                    state_reg <= S_TMAC;
                end
                S_TMAC:
                begin
                    state_reg <= S_TEND;
                end
                S_TEND:
                begin
                    if (out_phase_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (int'(u_reg) == HIDDEN_UNITS - 1)
                    begin
                        u_reg         <= '0;
                        out_phase_reg <= 1'b1;
                        state_reg     <= S_OBIAS;
                    end
                    else
                    begin
                        u_reg     <= u_reg + U_W'(1);
                        base_reg  <= base_reg + WIDX_W'(5);
                        k_reg     <= '0;
                        state_reg <= S_HBIAS;
                    end
                end
                S_OBIAS:
                begin
                    state_reg <= S_OMAC;
                end
                S_OMAC:
                begin
                    if (int'(u_reg) == HIDDEN_UNITS - 1)
                    begin
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        u_reg <= u_reg + U_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers: inputs, tanh argument, hidden outputs and result.
    always_ff @(posedge clk)
    begin
        if (accept && (cmd.opcode == OP_INFER))
        begin
            x_reg[0] <= cmd.in_height;
            x_reg[1] <= cmd.in_distance;
            x_reg[2] <= cmd.in_velocity;
            x_reg[3] <= cmd.in_offset;
        end
        if (state_reg == S_ROUND)
        begin
            tx_reg <= round_sat;
        end
        if ((state_reg == S_TEND) && !out_phase_reg)
        begin
            hid_reg[u_reg] <= t_y;
        end
        if ((state_reg == S_TEND) && out_phase_reg)
        begin
            result_reg.probability <= prob_sat;
            result_reg.flap        <= (prob_sat > 16'd32768);
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== tb/mlp_4_5_1_inference_core_tb.sv =====
// ============================================================================
// mlp_4_5_1_inference_core_tb
// Self-checking bench for the 4-5-1 perceptron core. It issues a directed set
// of inference and weight-write items, then a long random mix. A scoreboard
// keeps its own copy of the weight store and predicts the probability and
// flap bit of every inference item. Every done strobe is compared with the
// oldest prediction.
// ============================================================================
module mlp_4_5_1_inference_core_tb;

    import mlp_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_GAP      = 8;

    // Prediction and checking of inference results.
    class mlp_scoreboard;
        logic signed [15:0] weights [WEIGHT_COUNT];
        mlp_out_t           predicted [$];
        int errors;
        int infers;
        int writes;
        int dropped_writes;
        int checked;
        int saturated;
        int flaps;

        function new();
            int i;
            for (i = 0; i < WEIGHT_COUNT; i++)
            begin
                weights[i] = (i < GENE_COUNT) ? GENE_RESET[i] : 16'sd0;
            end
            errors = 0;
            infers = 0;
            writes = 0;
            dropped_writes = 0;
            checked = 0;
            saturated = 0;
            flaps = 0;
        endfunction

        // Add half an output step, then shift down with floor.
        function longint round_down(longint v, int sh);
            return (v + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        // Clamp to the signed Q3.12 range.
        function int clamp_q312(longint v);
            if (v > 32767)
            begin
                return 32767;
            end
            if (v < -32768)
            begin
                return -32768;
            end
            return int'(v);
        endfunction

        // Piecewise-linear tanh: Q3.12 in, Q1.14 out, odd about zero.
        function int tanh_approx(int x);
            int mag;
            int seg;
            int frac;
            int lo;
            int hi;
            int y;
            mag  = (x < 0) ? -x : x;
            seg  = mag >> 11;
            frac = mag & 2047;
            if (seg >= TANH_KNOTS - 1)
            begin
                y = int'(TANH_KNOT[TANH_KNOTS - 1]);
            end
            else
            begin
                lo = int'(TANH_KNOT[seg]);
                hi = int'(TANH_KNOT[seg + 1]);
                y  = lo + (((hi - lo) * frac + 1024) >> 11);
            end
            return (x < 0) ? -y : y;
        endfunction

        // Full forward pass over the local weight copy.
        function mlp_out_t forward(mlp_in_t c);
            longint   acc;
            int       x [4];
            int       hid [HIDDEN_UNITS];
            int       half_sum;
            int       t;
            int       prob;
            int       u;
            int       k;
            mlp_out_t r;
            x[0] = int'($signed(c.in_height));
            x[1] = int'($signed(c.in_distance));
            x[2] = int'($signed(c.in_velocity));
            x[3] = int'($signed(c.in_offset));
            for (u = 0; u < HIDDEN_UNITS; u++)
            begin
                acc = longint'(weights[5 * u + 4]) * 4096;
                for (k = 0; k < 4; k++)
                begin
                    acc += longint'(x[k]) * longint'(weights[5 * u + k]);
                end
                hid[u] = tanh_approx(clamp_q312(round_down(acc, 14)));
            end
            acc = longint'(weights[6 * HIDDEN_UNITS]) * 16384;
            for (u = 0; u < HIDDEN_UNITS; u++)
            begin
                acc += longint'(hid[u]) * longint'(weights[5 * HIDDEN_UNITS + u]);
            end
            half_sum = clamp_q312(round_down(acc, 17));
            t = tanh_approx(half_sum);
            prob = 2 * (16384 + t);
            if (prob > 65535)
            begin
                prob = 65535;
            end
            r.probability = prob[15:0];
            r.flap = (prob > 32768);
            return r;
        endfunction

        // Record an accepted item: a write updates the store, an inference
        // queues its prediction.
        function void note_item(mlp_in_t c);
            mlp_out_t r;
            if (c.opcode == OP_WRITE)
            begin
                writes++;
                if (int'(c.weight_index) < WEIGHT_COUNT)
                begin
                    weights[c.weight_index] = c.weight_value;
                end
                else
                begin
                    dropped_writes++;
                end
            end
            else
            begin
                infers++;
                r = forward(c);
                if (r.probability == 16'hFFFF)
                begin
                    saturated++;
                end
                if (r.flap)
                begin
                    flaps++;
                end
                predicted.push_back(r);
            end
        endfunction

        // Compare one result item with the oldest prediction.
        function void check_result(mlp_out_t r);
            mlp_out_t e;
            if (predicted.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual probability %0d flap %0d",
                         $time, r.probability, r.flap);
                return;
            end
            e = predicted.pop_front();
            checked++;
            if (r.probability !== e.probability)
            begin
                errors++;
                $display("%0t: probability mismatch, expected %0d, actual %0d",
                         $time, e.probability, r.probability);
            end
            if (r.flap !== e.flap)
            begin
                errors++;
                $display("%0t: flap mismatch, expected %0d, actual %0d",
                         $time, e.flap, r.flap);
            end
        endfunction

        function int outstanding();
            return predicted.size();
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    mlp_in_t  cmd;
    mlp_out_t result;
    logic     done;
    int       cycles;

    mlp_scoreboard sb = new();

    mlp_4_5_1_inference_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .result (result),
        .done   (done)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Cycle limit as a guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d results outstanding",
                     $time, sb.outstanding());
            $display("mlp_4_5_1_inference_core_tb: errors");
            $finish;
        end
    end

    // Result monitor: every done strobe carries one result item.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            sb.check_result(result);
        end
    end

    // Build an inference item; the write fields carry random noise.
    function automatic mlp_in_t infer_item(logic [15:0] h, logic [15:0] d,
                                           logic [15:0] v, logic [15:0] o);
        mlp_in_t c;
        c.opcode       = OP_INFER;
        c.in_height    = h;
        c.in_distance  = d;
        c.in_velocity  = v;
        c.in_offset    = o;
        c.weight_index = 5'($urandom);
        c.weight_value = 16'($urandom);
        return c;
    endfunction

    // Build a weight write item; the input fields carry random noise.
    function automatic mlp_in_t write_item(logic [4:0] slot, logic [15:0] value);
        mlp_in_t c;
        c.opcode       = OP_WRITE;
        c.in_height    = 16'($urandom);
        c.in_distance  = 16'($urandom);
        c.in_velocity  = 16'($urandom);
        c.in_offset    = 16'($urandom);
        c.weight_index = slot;
        c.weight_value = value;
        return c;
    endfunction

    // Random 16-bit field: full range, extremes, or a moderate spread.
    function automatic logic [15:0] rand_field();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return 16'($urandom);
        end
        if (pick == 4)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h7FFF;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom_range(0, 16383)) - 16'd8192;
    endfunction

    // Present one item after a random gap and hold it until it is taken.
    task automatic send_item(input mlp_in_t c);
        int gap;
        gap = $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        sb.note_item(c);
    endtask

    // Stimulus and end of run.
    initial
    begin
        int n;
        int pick;
        rst_n  = 1'b0;
        start  = 1'b0;
        cmd    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero, extreme and mixed inputs on the reset genes.
        send_item(infer_item(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(infer_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_item(infer_item(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_item(infer_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_item(infer_item(16'h1000, 16'hF800, 16'h0001, 16'hFFFF));

        // A write to the slot past the store must leave the weights alone.
        send_item(write_item(5'd31, 16'h7FFF));
        send_item(infer_item(16'h0000, 16'h0000, 16'h0000, 16'h0000));

        // Output weights matched to the hidden signs drive the probability to one.
        send_item(write_item(5'd25, 16'h8000));
        send_item(write_item(5'd26, 16'h7FFF));
        send_item(write_item(5'd27, 16'h7FFF));
        send_item(write_item(5'd28, 16'h7FFF));
        send_item(write_item(5'd29, 16'h8000));
        send_item(write_item(5'd30, 16'h7FFF));
        send_item(infer_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));

        // The mirrored weights drive it to zero.
        send_item(write_item(5'd25, 16'h7FFF));
        send_item(write_item(5'd26, 16'h8000));
        send_item(write_item(5'd27, 16'h8000));
        send_item(write_item(5'd28, 16'h8000));
        send_item(write_item(5'd29, 16'h7FFF));
        send_item(write_item(5'd30, 16'h8000));
        send_item(infer_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));

        send_item(write_item(5'd0, 16'h8000));
        send_item(write_item(5'd30, 16'h0000));
        send_item(infer_item(rand_field(), rand_field(), rand_field(), rand_field()));

        // Random part: mostly inferences, with weight writes mixed in.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                send_item(write_item(5'($urandom_range(0, 31)), rand_field()));
            end
            else
            begin
                send_item(infer_item(rand_field(), rand_field(), rand_field(), rand_field()));
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for stray strobes.
        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d inference items and %0d weight writes (%0d to the unused slot).",
                 sb.infers, sb.writes, sb.dropped_writes);
        $display("Checked %0d results; %0d saturated at one, %0d with flap set.",
                 sb.checked, sb.saturated, sb.flaps);
        if (sb.errors == 0)
        begin
            $display("mlp_4_5_1_inference_core_tb: clean");
        end
        else
        begin
            $display("mlp_4_5_1_inference_core_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mlp_pkg.sv
sv/mlp_weight_store.sv
sv/mlp_mac.sv
sv/mlp_4_5_1_inference_core.sv
tb/mlp_4_5_1_inference_core_tb.sv
